FILE: hdl/ddo_pkg.sv
// Shared types, codes and constants for the differential drive odometry block.
`default_nettype none

package ddo_pkg;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [31:0]        elapsed_us;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic [15:0]        new_heading;
  } ddo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading_now;
    logic signed [31:0] speed_now;
    logic signed [31:0] curvature_now;
    logic [31:0]        goal_distance;
    logic signed [15:0] goal_angle;
  } ddo_out_t;

  localparam logic [1:0] OP_UPDATE   = 2'd0;
  localparam logic [1:0] OP_SET_POSE = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  localparam logic [1:0] REG_DIST   = 2'd0;
  localparam logic [1:0] REG_ANGLE  = 2'd1;
  localparam logic [1:0] REG_GOAL_X = 2'd2;
  localparam logic [1:0] REG_GOAL_Y = 2'd3;

  localparam int MUL_AW = 64;
  localparam int MUL_BW = 32;
  localparam int DIV_NW = 96;
  localparam int DIV_DW = 83;
  localparam int ATAN_IW = 5;

  localparam logic [31:0] US_PER_S    = 32'd1000000;
  localparam logic [31:0] PI_Q29      = 32'd1686629713;
  localparam logic [51:0] CORDIC_GAIN = 52'd652032874;
  localparam logic [31:0] SAT_POS     = 32'h7FFFFFFF;
  localparam logic [31:0] SAT_NEG     = 32'h80000000;

  localparam logic [29:0] ATAN_TAB [0:23] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
  };

endpackage

`default_nettype wire

FILE: hdl/ddo_stream_if.sv
// Valid/ready stream interface carrying one item of type T.
`default_nettype none

interface ddo_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/ddo_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module ddo_mul #(
  parameter int AW = 64,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic [AW+BW-1:0] p
);
  localparam int CNTW = $clog2(BW + 1);

  logic [CNTW-1:0] cnt;
  logic [AW-1:0]   a_r;
  logic [AW:0]     sum;

  assign sum  = {1'b0, p[AW+BW-1:BW]} + (p[0] ? {1'b0, a_r} : (AW+1)'(0));
  assign busy = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNTW'(BW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p   <= {AW'(0), b};
    end else if (busy) begin
      p <= {sum, p[BW-1:1]};
    end
  end
endmodule

`default_nettype wire

FILE: hdl/ddo_div.sv
// Restoring unsigned divider, one quotient bit per cycle, saturating at a limit.
`default_nettype none

module ddo_div #(
  parameter int NW = 96,
  parameter int DW = 83,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [QW-1:0] lim,
  output logic          busy,
  output logic [QW-1:0] q
);
  localparam int CNTW = $clog2(QW + 1);

  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   den_r;
  logic [QW-1:0]   quo;
  logic [QW-1:0]   lim_r;
  logic            den_zero;
  logic            num_zero;
  logic            ovf;
  logic [DW:0]     trial;
  logic            take;

  assign trial = {rem, quo[QW-1]};
  assign take  = (trial >= {1'b0, den_r});
  assign busy  = (cnt != '0);

  always_comb begin
    if (den_zero) begin
      q = num_zero ? '0 : lim_r;
    end else if (ovf || (quo > lim_r)) begin
      q = lim_r;
    end else begin
      q = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNTW'(QW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r    <= den;
      lim_r    <= lim;
      rem      <= DW'(num[NW-1:QW]);
      quo      <= num[QW-1:0];
      den_zero <= (den == '0);
      num_zero <= (num == '0);
      ovf      <= (DW'(num[NW-1:QW]) >= den);
    end else if (busy) begin
      rem <= take ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      quo <= {quo[QW-2:0], take};
    end
  end
endmodule

`default_nettype wire

FILE: hdl/differential_drive_odometry_core.sv
// Differential drive odometry core: pose update, speed, curvature, goal distance and goal bearing.
// One item is in work at a time, using the serial multipliers and dividers, the CORDIC and
// the square root. A new item is taken while the previous result still waits in the
// output register. Synchronous reset clears the pose, counts, speed, curvature, registers
// and the output valid flag.
`default_nettype none

module differential_drive_odometry_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  ddo_stream_if.sink   cmd,
  ddo_stream_if.source res
);
  import ddo_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SD   = 4'd1;
  localparam logic [3:0] S_A    = 4'd2;
  localparam logic [3:0] S_AW   = 4'd3;
  localparam logic [3:0] S_B    = 4'd4;
  localparam logic [3:0] S_BW   = 4'd5;
  localparam logic [3:0] S_P    = 4'd6;
  localparam logic [3:0] S_GOAL = 4'd7;
  localparam logic [3:0] S_G    = 4'd8;
  localparam logic [3:0] S_GW   = 4'd9;
  localparam logic [3:0] S_SQ   = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return SAT_POS;
    end else if (v < -35'sd2147483648) begin
      return SAT_NEG;
    end else begin
      return v[31:0];
    end
  endfunction

  logic [3:0] state;
  logic       acc;

  logic [31:0]        dist_tick;
  logic [31:0]        angle_tick;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;

  logic [31:0]        last_left;
  logic [31:0]        last_right;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;
  logic signed [31:0] speed;
  logic signed [31:0] curv;

  logic [1:0]         op;
  logic [31:0]        elapsed;
  logic [31:0]        dl;
  logic [31:0]        dr;
  logic signed [32:0] s_val;
  logic signed [32:0] d_val;
  logic [63:0]        prod;
  logic [63:0]        dmag_a;
  logic [30:0]        tmag;
  logic [31:0]        c_abs;
  logic [31:0]        s_abs;
  logic               c_neg;
  logic               s_neg;
  logic signed [33:0] step_x;
  logic signed [33:0] step_y;
  logic signed [32:0] gx;
  logic signed [32:0] gy;
  logic [15:0]        g_angle;
  logic [31:0]        g_dist;

  logic     out_valid;
  ddo_out_t out_data;
  logic     out_load;

  // serial units
  logic [MUL_AW-1:0]        mul_a [4];
  logic [MUL_BW-1:0]        mul_b [4];
  logic [MUL_AW+MUL_BW-1:0] mul_p [4];
  logic [3:0]               mul_busy;
  logic                     mul_start;
  logic                     div_start;
  logic [1:0]               div_busy;
  logic [31:0]              q_speed;
  logic [31:0]              q_curv;

  // cordic
  logic                     c_run;
  logic                     c_rot;
  logic                     c_flip;
  logic [ATAN_IW-1:0]       ci;
  logic signed [51:0]       cx;
  logic signed [51:0]       cy;
  logic signed [33:0]       cz;
  logic signed [51:0]       xs;
  logic signed [51:0]       ys;
  logic signed [33:0]       at;
  logic                     c_dir;
  logic                     c_last;
  logic                     flip_n;
  logic [31:0]              th_n;
  logic signed [51:0]       vx0;
  logic signed [51:0]       vy0;

  // square root
  logic [65:0] sq_v;
  logic [35:0] sq_r;
  logic [32:0] sq_q;
  logic [5:0]  sq_cnt;
  logic [35:0] sq_r2;
  logic [35:0] sq_t;
  logic        sq_ge;

  // datapath helpers
  logic [31:0]        dl_in;
  logic [31:0]        dr_in;
  logic [32:0]        s_mag;
  logic [32:0]        d_mag;
  logic [31:0]        gx_abs;
  logic [31:0]        gy_abs;
  logic [32:0]        gx_neg_v;
  logic [32:0]        gy_neg_v;
  logic [64:0]        trav_rnd;
  logic [30:0]        tmag_n;
  logic [31:0]        hsum;
  logic [51:0]        cx_neg_v;
  logic [51:0]        cy_neg_v;
  logic [63:0]        pmx;
  logic [63:0]        pmy;
  logic [63:0]        rx;
  logic [63:0]        ry;
  logic signed [34:0] nx;
  logic signed [34:0] ny;
  logic [31:0]        gh_sum;
  logic [15:0]        gh;
  logic               g_zero;

  assign acc       = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign res.valid = out_valid;
  assign res.data  = out_data;
  assign out_load  = (state == S_OUT) && (!out_valid || res.ready);

  assign dl_in    = cmd.data.left_count - last_left;
  assign dr_in    = cmd.data.right_count - last_right;
  assign s_mag    = s_val[32] ? 33'(-s_val) : 33'(s_val);
  assign d_mag    = d_val[32] ? 33'(-d_val) : 33'(d_val);
  assign gx_neg_v = 33'(-gx);
  assign gy_neg_v = 33'(-gy);
  assign gx_abs   = gx[32] ? gx_neg_v[31:0] : gx[31:0];
  assign gy_abs   = gy[32] ? gy_neg_v[31:0] : gy[31:0];

  assign trav_rnd = {1'b0, mul_p[0][63:0]} + 65'd256;
  assign tmag_n   = (|trav_rnd[64:40]) ? SAT_POS[30:0] : trav_rnd[39:9];
  assign hsum     = mul_p[1][31:0] + 32'h8000;
  assign cx_neg_v = 52'(-cx);
  assign cy_neg_v = 52'(-cy);

  assign pmx = {2'b0, mul_p[0][61:0]};
  assign pmy = {2'b0, mul_p[1][61:0]};
  assign rx  = ((s_val[32] ^ c_neg) ? -pmx : pmx) + 64'h20000000;
  assign ry  = ((s_val[32] ^ s_neg) ? -pmy : pmy) + 64'h20000000;
  assign nx  = 35'(pos_x) + 35'(step_x);
  assign ny  = 35'(pos_y) + 35'(step_y);

  assign gh_sum = cz[31:0] + 32'h8000;
  assign gh     = gh_sum[31:16];
  assign g_zero = (gx == '0) && (gy == '0);

  // multiplier operand selection
  assign mul_start = (state == S_A) || (state == S_B) || (state == S_G);

  always_comb begin
    case (state)
      S_A: begin
        mul_a[0] = {31'b0, s_mag};
        mul_b[0] = dist_tick;
        mul_a[1] = {32'b0, d_val[31:0]};
        mul_b[1] = angle_tick;
        mul_a[2] = {31'b0, d_mag};
        mul_b[2] = angle_tick;
        mul_a[3] = '0;
        mul_b[3] = '0;
      end
      S_B: begin
        mul_a[0] = {33'b0, tmag};
        mul_b[0] = c_abs;
        mul_a[1] = {33'b0, tmag};
        mul_b[1] = s_abs;
        mul_a[2] = prod;
        mul_b[2] = US_PER_S;
        mul_a[3] = dmag_a;
        mul_b[3] = PI_Q29;
      end
      default: begin
        mul_a[0] = {32'b0, gx_abs};
        mul_b[0] = gx_abs;
        mul_a[1] = {32'b0, gy_abs};
        mul_b[1] = gy_abs;
        mul_a[2] = '0;
        mul_b[2] = '0;
        mul_a[3] = '0;
        mul_b[3] = '0;
      end
    endcase
  end

  for (genvar k = 0; k < 4; k++) begin : g_mul
    ddo_mul #(
      .AW(MUL_AW),
      .BW(MUL_BW)
    ) u_mul (
      .clk  (clk),
      .rst  (rst),
      .start(mul_start),
      .a    (mul_a[k]),
      .b    (mul_b[k]),
      .busy (mul_busy[k]),
      .p    (mul_p[k])
    );
  end

  assign div_start = (state == S_P);

  ddo_div #(
    .NW(DIV_NW),
    .DW(DIV_DW),
    .QW(32)
  ) u_div_speed (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (mul_p[2]),
    .den  ({42'b0, elapsed, 9'b0}),
    .lim  (s_val[32] ? SAT_NEG : SAT_POS),
    .busy (div_busy[0]),
    .q    (q_speed)
  );

  ddo_div #(
    .NW(DIV_NW),
    .DW(DIV_DW),
    .QW(32)
  ) u_div_curv (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (mul_p[3]),
    .den  ({prod, 19'b0}),
    .lim  (d_val[32] ? SAT_NEG : SAT_POS),
    .busy (div_busy[1]),
    .q    (q_curv)
  );

  // cordic: rotation for sin/cos of the heading, vectoring for the goal bearing
  assign xs     = cx >>> ci;
  assign ys     = cy >>> ci;
  assign at     = {4'b0, ATAN_TAB[ci]};
  assign c_dir  = c_rot ? ~cz[33] : cy[51];
  assign c_last = (ci == ATAN_IW'(CORDIC_STEPS - 1));
  assign flip_n = heading[15] ^ heading[14];
  assign th_n   = {heading[15] ^ flip_n, heading[14:0], 16'h0};
  assign vx0    = {{3{gx[32]}}, gx, 16'b0};
  assign vy0    = {{3{gy[32]}}, gy, 16'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      c_run <= 1'b0;
    end else if ((state == S_A) || (state == S_G)) begin
      c_run <= 1'b1;
    end else if (c_run && c_last) begin
      c_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_A) begin
      c_rot  <= 1'b1;
      c_flip <= flip_n;
      ci     <= '0;
      cx     <= CORDIC_GAIN;
      cy     <= '0;
      cz     <= {{2{th_n[31]}}, th_n};
    end else if (state == S_G) begin
      c_rot <= 1'b0;
      ci    <= '0;
      cx    <= gx[32] ? -vx0 : vx0;
      cy    <= gx[32] ? -vy0 : vy0;
      cz    <= gx[32] ? 34'sh080000000 : 34'sh0;
    end else if (c_run) begin
      ci <= ci + 1'b1;
      if (c_dir) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - at;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + at;
      end
    end
  end

  // square root, two radicand bits per cycle
  assign sq_r2 = {sq_r[33:0], sq_v[65:64]};
  assign sq_t  = {1'b0, sq_q, 2'b01};
  assign sq_ge = (sq_r2 >= sq_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_cnt <= '0;
    end else if ((state == S_GW) && !(|mul_busy) && !c_run) begin
      sq_cnt <= 6'd33;
    end else if (sq_cnt != '0) begin
      sq_cnt <= sq_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_GW) && !(|mul_busy) && !c_run) begin
      sq_v <= 66'(mul_p[0][63:0]) + 66'(mul_p[1][63:0]);
      sq_r <= '0;
      sq_q <= '0;
    end else if (sq_cnt != '0) begin
      sq_v <= {sq_v[63:0], 2'b0};
      sq_r <= sq_ge ? (sq_r2 - sq_t) : sq_r2;
      sq_q <= {sq_q[31:0], sq_ge};
    end
  end

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dist_tick  <= '0;
      angle_tick <= '0;
      goal_x     <= '0;
      goal_y     <= '0;
      last_left  <= '0;
      last_right <= '0;
      pos_x      <= '0;
      pos_y      <= '0;
      heading    <= '0;
      speed      <= '0;
      curv       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_DIST:   dist_tick  <= wr_data;
          REG_ANGLE:  angle_tick <= wr_data;
          REG_GOAL_X: goal_x     <= wr_data;
          REG_GOAL_Y: goal_y     <= wr_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (acc) begin
            case (cmd.data.operation)
              OP_UPDATE: begin
                last_left  <= cmd.data.left_count;
                last_right <= cmd.data.right_count;
                state      <= S_SD;
              end
              OP_SET_POSE: begin
                pos_x   <= cmd.data.new_x;
                pos_y   <= cmd.data.new_y;
                heading <= cmd.data.new_heading;
                state   <= S_GOAL;
              end
              OP_CLEAR: begin
                last_left  <= '0;
                last_right <= '0;
                curv       <= '0;
                state      <= S_GOAL;
              end
              default: state <= S_GOAL;
            endcase
          end
        end
        S_SD: state <= S_A;
        S_A:  state <= S_AW;
        S_AW: begin
          if (!(|mul_busy) && !c_run) begin
            heading <= heading + hsum[31:16];
            state   <= S_B;
          end
        end
        S_B: state <= S_BW;
        S_BW: begin
          if (!(|mul_busy)) begin
            state <= S_P;
          end
        end
        S_P: begin
          pos_x <= sat32(nx);
          pos_y <= sat32(ny);
          state <= S_GOAL;
        end
        S_GOAL: state <= S_G;
        S_G:    state <= S_GW;
        S_GW: begin
          if (!(|mul_busy) && !c_run) begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if ((sq_cnt == '0) && !(|div_busy)) begin
            if (op == OP_UPDATE) begin
              speed <= s_val[32] ? -q_speed : q_speed;
              if (s_val[32] || (s_val == '0) || (dist_tick == '0)) begin
                curv <= '0;
              end else begin
                curv <= d_val[32] ? -q_curv : q_curv;
              end
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (acc) begin
          op      <= cmd.data.operation;
          elapsed <= cmd.data.elapsed_us;
          dl      <= dl_in;
          dr      <= dr_in;
        end
      end
      S_SD: begin
        s_val <= 33'(signed'(dl)) + 33'(signed'(dr));
        d_val <= 33'(signed'(dr)) - 33'(signed'(dl));
      end
      S_AW: begin
        prod   <= mul_p[0][63:0];
        dmag_a <= mul_p[2][63:0];
        tmag   <= tmag_n;
        c_abs  <= cx[51] ? cx_neg_v[31:0] : cx[31:0];
        s_abs  <= cy[51] ? cy_neg_v[31:0] : cy[31:0];
        c_neg  <= c_flip ^ cx[51];
        s_neg  <= c_flip ^ cy[51];
      end
      S_BW: begin
        step_x <= rx[63:30];
        step_y <= ry[63:30];
      end
      S_GOAL: begin
        gx <= 33'(goal_x) - 33'(pos_x);
        gy <= 33'(goal_y) - 33'(pos_y);
      end
      S_GW: begin
        g_angle <= (g_zero ? 16'd0 : gh) - heading;
      end
      S_SQ: begin
        g_dist <= sq_q[32] ? 32'hFFFFFFFF : sq_q[31:0];
      end
      default: ;
    endcase

    if (out_load) begin
      out_data.pos_x         <= pos_x;
      out_data.pos_y         <= pos_y;
      out_data.heading_now   <= heading;
      out_data.speed_now     <= speed;
      out_data.curvature_now <= curv;
      out_data.goal_distance <= g_dist;
      out_data.goal_angle    <= g_angle;
    end
  end
endmodule

`default_nettype wire

FILE: bench/tb_differential_drive_odometry_core.sv
// Self-checking testbench for the differential drive odometry core.
`default_nettype none

module tb_differential_drive_odometry_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ddo_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [31:0] wr_data;

  ddo_stream_if #(.T(ddo_in_t))  cmd_if ();
  ddo_stream_if #(.T(ddo_out_t)) res_if ();

  differential_drive_odometry_core #(.CORDIC_STEPS(CORDIC_STEPS)) DUT (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .cmd(cmd_if), .res(res_if)
  );

  // predictor state
  logic [31:0] cfg_dist, cfg_ang, cfg_gx, cfg_gy;
  logic [31:0] odo_last_l, odo_last_r;
  longint      odo_x, odo_y, odo_speed, odo_curv;
  logic [15:0] odo_head;

  ddo_out_t pose_q[$];
  int       mismatches;
  int       cycles;
  bit       calm;
  int       res_stall;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void cordic_sincos(input logic [15:0] ang, output longint c,
                                        output longint sn);
    logic [31:0] th;
    logic [31:0] probe;
    bit          flip;
    longint      x, y, z, xs, ys;
    th = {ang, 16'h0000};
    flip = 1'b0;
    x = 652032874;
    y = 0;
    probe = th + 32'h40000000;
    if (probe >= 32'h80000000) begin
      th = th + 32'h80000000;
      flip = 1'b1;
    end
    z = longint'($signed(th));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TAB[i]);
      end
    end
    c = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic logic [15:0] cordic_bearing(input longint dy, input longint dx);
    longint      x, y, z, xs, ys;
    logic [63:0] rz;
    if (dx == 0 && dy == 0) return 16'h0000;
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'sh80000000;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TAB[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TAB[i]);
      end
    end
    rz = 64'(z) + 64'h8000;
    return rz[31:16];
  endfunction

  function automatic logic [31:0] range_sqrt(input logic [127:0] v);
    logic [63:0] r, c, sq;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = c * c;
      if (v >= {64'd0, sq}) r = c;
    end
    return r[31:0];
  endfunction

  function automatic logic [63:0] quot_sat(input logic [127:0] num, input logic [127:0] den,
                                           input logic [63:0] lim);
    logic [127:0] q;
    if (den == 0) return (num == 0) ? 64'd0 : lim;
    if (num >= (den << 32)) return lim;
    q = num / den;
    return (q > {64'd0, lim}) ? lim : q[63:0];
  endfunction

  function automatic void advance_pose(input ddo_in_t it);
    logic [31:0] wl, wr;
    longint      dl, dr, s, d, trav, c, sn;
    logic [63:0] smag, dmag, prod, tmag, hprod, q, dprod, lim;
    wl = it.left_count - odo_last_l;
    wr = it.right_count - odo_last_r;
    dl = longint'($signed(wl));
    dr = longint'($signed(wr));
    s = dl + dr;
    d = dr - dl;
    smag = 64'(s < 0 ? -s : s);
    dmag = 64'(d < 0 ? -d : d);
    prod = smag * 64'(cfg_dist);
    tmag = (prod + 64'd256) >> 9;
    odo_last_l = it.left_count;
    odo_last_r = it.right_count;
    if (tmag > 64'h7FFFFFFF) tmag = 64'h7FFFFFFF;
    trav = s < 0 ? -longint'(tmag) : longint'(tmag);
    cordic_sincos(odo_head, c, sn);
    odo_x = sat32(odo_x + ((trav * c + 64'sh20000000) >>> 30));
    odo_y = sat32(odo_y + ((trav * sn + 64'sh20000000) >>> 30));
    hprod = 64'(d) * 64'(cfg_ang) + 64'h8000;
    odo_head = odo_head + hprod[31:16];
    lim = s < 0 ? 64'h80000000 : 64'h7FFFFFFF;
    q = quot_sat(128'(prod) * 128'(US_PER_S), 128'(it.elapsed_us) << 9, lim);
    odo_speed = s < 0 ? -longint'(q) : longint'(q);
    if (s <= 0 || cfg_dist == 0) begin
      odo_curv = 0;
    end else begin
      dprod = dmag * 64'(cfg_ang);
      lim = d < 0 ? 64'h80000000 : 64'h7FFFFFFF;
      q = quot_sat(128'(dprod) * 128'(PI_Q29), 128'(prod) << 19, lim);
      odo_curv = d < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic ddo_out_t predict_pose(input ddo_in_t it);
    ddo_out_t    o;
    longint      gx, gy;
    logic [63:0] ax, ay;
    logic [15:0] gh;
    case (it.operation)
      OP_UPDATE: advance_pose(it);
      OP_SET_POSE: begin
        odo_x = longint'(it.new_x);
        odo_y = longint'(it.new_y);
        odo_head = it.new_heading;
      end
      OP_CLEAR: begin
        odo_last_l = 0;
        odo_last_r = 0;
        odo_curv = 0;
      end
      default: ;
    endcase
    gx = longint'($signed(cfg_gx)) - odo_x;
    gy = longint'($signed(cfg_gy)) - odo_y;
    ax = 64'(gx < 0 ? -gx : gx);
    ay = 64'(gy < 0 ? -gy : gy);
    gh = cordic_bearing(gy, gx);
    o.pos_x = odo_x[31:0];
    o.pos_y = odo_y[31:0];
    o.heading_now = odo_head;
    o.speed_now = odo_speed[31:0];
    o.curvature_now = odo_curv[31:0];
    o.goal_distance = range_sqrt(128'(ax) * 128'(ax) + 128'(ay) * 128'(ay));
    o.goal_angle = gh - odo_head;
    return o;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stalls and compare against the oldest expectation
  always @(posedge clk) begin
    int       nstall;
    ddo_out_t exp_pose;
    if (rst) begin
      res_if.ready <= 1'b0;
      res_stall <= 0;
    end else if (res_if.valid && res_if.ready) begin
      if (pose_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", res_if.data);
      end else begin
        exp_pose = pose_q.pop_front();
        if (res_if.data !== exp_pose) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %p got %p", exp_pose, res_if.data);
        end
      end
      nstall = calm ? 0 : $urandom_range(0, 19);
      res_stall <= nstall;
      res_if.ready <= (nstall == 0);
    end else if (res_stall > 0) begin
      res_stall <= res_stall - 1;
      res_if.ready <= (res_stall == 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic send_item(input ddo_in_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data <= it;
    do @(posedge clk); while (!cmd_if.ready);
    pose_q.push_back(predict_pose(it));
  endtask

  task automatic drain_results();
    if (cmd_if.valid) cmd_if.valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    drain_results();
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_DIST:   cfg_dist = val;
      REG_ANGLE:  cfg_ang = val;
      REG_GOAL_X: cfg_gx = val;
      default:    cfg_gy = val;
    endcase
  endtask

  function automatic ddo_in_t make_item(input logic [1:0] op, input logic [31:0] l,
                                        input logic [31:0] r, input logic [31:0] us);
    ddo_in_t it;
    it.operation = op;
    it.left_count = l;
    it.right_count = r;
    it.elapsed_us = us;
    it.new_x = $urandom;
    it.new_y = $urandom;
    it.new_heading = $urandom;
    return it;
  endfunction

  function automatic ddo_in_t make_pose(input logic [31:0] x, input logic [31:0] y,
                                        input logic [15:0] h);
    ddo_in_t it;
    it = make_item(OP_SET_POSE, $urandom, $urandom, $urandom);
    it.new_x = x;
    it.new_y = y;
    it.new_heading = h;
    return it;
  endfunction

  task automatic test_update_extremes();
    write_reg(REG_DIST, 32'h00100000);
    write_reg(REG_ANGLE, 32'h00080000);
    write_reg(REG_GOAL_X, 32'h00050000);
    write_reg(REG_GOAL_Y, 32'hFFFD0000);
    send_item(make_item(OP_UPDATE, 0, 0, 0));
    send_item(make_item(OP_UPDATE, 100, 120, 0));
    send_item(make_item(OP_UPDATE, 200, 260, 20000));
    send_item(make_item(OP_UPDATE, 150, 180, 20000));
    send_item(make_item(OP_UPDATE, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF));
    send_item(make_item(OP_UPDATE, 32'h80000000, 32'h7FFFFFFF, 1));
    send_item(make_item(OP_UPDATE, 32'h80000010, 32'h7FFFFFF0, 1000));
  endtask

  task automatic test_set_pose_and_goal();
    send_item(make_pose(32'h7FFFFFFF, 32'h80000000, 16'hFFFF));
    send_item(make_pose(32'h80000000, 32'h7FFFFFFF, 16'h0000));
    send_item(make_pose(32'h00050000, 32'hFFFD0000, 16'h4000));
    send_item(make_pose(32'h00080000, 32'hFFFD0000, 16'h0000));
    send_item(make_pose(32'h00050000, 32'hFFF80000, 16'hC000));
    send_item(make_item(OP_UPDATE, 10, 10, 500));
  endtask

  task automatic test_clear_and_unused();
    send_item(make_item(OP_CLEAR, $urandom, $urandom, $urandom));
    send_item(make_item(OP_UPDATE, 40, 10, 700));
    send_item(make_item(2'd3, $urandom, $urandom, $urandom));
    send_item(make_item(OP_CLEAR, 0, 0, 0));
  endtask

  task automatic test_zero_tick_distance();
    write_reg(REG_DIST, 32'h00000000);
    write_reg(REG_ANGLE, 32'hFFFFFFFF);
    send_item(make_item(OP_UPDATE, 5, 90, 100));
    send_item(make_item(OP_UPDATE, 3, 2, 0));
    write_reg(REG_DIST, 32'hFFFFFFFF);
    write_reg(REG_GOAL_X, 32'h80000000);
    write_reg(REG_GOAL_Y, 32'h7FFFFFFF);
    send_item(make_item(OP_UPDATE, 8, 100, 1));
    send_item(make_item(OP_UPDATE, 8, 101, 0));
  endtask

  function automatic logic [31:0] pick_config(input bit signed_reg);
    case ($urandom_range(0, 5))
      0: return 32'h00000000;
      1: return 32'hFFFFFFFF;
      2: return signed_reg ? 32'h7FFFFFFF : $urandom;
      3: return signed_reg ? 32'h80000000 : $urandom_range(32'h10000, 32'h400000);
      default: return signed_reg ? $urandom_range(0, 32'h01000000) - 32'h00800000
                                 : $urandom_range(32'h1000, 32'h100000);
    endcase
  endfunction

  function automatic ddo_in_t random_item();
    int          pick;
    logic [31:0] dl, dr;
    ddo_in_t     it;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      dl = $urandom_range(0, 4000) - 2000;
      dr = dl + $urandom_range(0, 400) - 200;
      if ($urandom_range(0, 19) == 0) begin
        dl = $urandom; dr = $urandom;
      end
      it = make_item(OP_UPDATE, odo_last_l + dl, odo_last_r + dr, $urandom_range(1, 100000));
      case ($urandom_range(0, 15))
        0: it.elapsed_us = 0;
        1: it.elapsed_us = $urandom;
        default: ;
      endcase
    end else if (pick < 85) begin
      it = make_pose($urandom_range(0, 32'h00400000) - 32'h00200000,
                     $urandom_range(0, 32'h00400000) - 32'h00200000, $urandom);
      if ($urandom_range(0, 3) == 0) begin
        it.new_x = $urandom; it.new_y = $urandom;
      end
    end else if (pick < 93) begin
      it = make_item(OP_CLEAR, $urandom, $urandom, $urandom);
    end else begin
      it = make_item(2'd3, $urandom, $urandom, $urandom);
    end
    return it;
  endfunction

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_DIST, pick_config(1'b0));
      write_reg(REG_ANGLE, pick_config(1'b0));
      write_reg(REG_GOAL_X, pick_config(1'b1));
      write_reg(REG_GOAL_Y, pick_config(1'b1));
      calm = (ph % 4 == 3);
      for (int n = 0; n < 230; n++) send_item(random_item());
      calm = 1'b0;
    end
  endtask

  initial begin
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= REG_DIST;
    wr_data <= '0;
    cmd_if.valid <= 1'b0;
    cmd_if.data <= '0;
    cycles = 0;
    mismatches = 0;
    calm = 1'b0;
    cfg_dist = 0; cfg_ang = 0; cfg_gx = 0; cfg_gy = 0;
    odo_last_l = 0; odo_last_r = 0;
    odo_x = 0; odo_y = 0; odo_speed = 0; odo_curv = 0; odo_head = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_update_extremes();
    test_set_pose_and_goal();
    test_clear_and_unused();
    test_zero_tick_distance();
    test_random_phases();
    drain_results();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hdl/ddo_pkg.sv
hdl/ddo_stream_if.sv
hdl/ddo_mul.sv
hdl/ddo_div.sv
hdl/differential_drive_odometry_core.sv
bench/tb_differential_drive_odometry_core.sv
